[rtl/core/lzwe_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// LZW encoder package
// Shared command and status types between controller and datapath.
// ---------------------------------------------------------------------------
package lzwe_pkg;

	localparam int unsigned BYTE_BITS   = 8;
	localparam int unsigned OUT_BITS    = 12;
	localparam int unsigned EPOCH_BITS  = 8;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_LOAD,
		DP_READ,
		DP_STEP,
		DP_INSERT,
		DP_CLEAR_STEP
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   take_hit;
		logic   set_byte;
		logic   clear_state;
	} dp_cmd_t;

	typedef struct packed {
		logic have_prefix;
		logic slot_valid;
		logic key_match;
		logic probe_done;
		logic can_insert;
		logic sweep_done;
		logic epoch_last;
	} dp_status_t;

endpackage
`default_nettype wire

[rtl/core/lzwe_datapath.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// LZW encoder datapath
// Holds the hashed dictionary, the probe address, the prefix and the
// next free code; acts on commands from the controller.
// ---------------------------------------------------------------------------
module lzwe_datapath #(
	parameter int unsigned CODE_BITS  = 12,
	parameter int unsigned HASH_SLOTS = 8192
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  lzwe_pkg::dp_cmd_t              cmd,
	input  wire [lzwe_pkg::BYTE_BITS-1:0]  in_byte,
	output lzwe_pkg::dp_status_t           status,
	output logic [CODE_BITS-1:0]           prefix
);
	import lzwe_pkg::*;

	localparam int unsigned AW   = $clog2(HASH_SLOTS);
	localparam int unsigned KW   = CODE_BITS + BYTE_BITS;
	localparam int unsigned TW   = KW + CODE_BITS;
	localparam int unsigned EW   = EPOCH_BITS + TW;
	localparam int unsigned NW   = CODE_BITS + 1;
	localparam int unsigned CW   = AW + 1;

	logic [EW-1:0]         mem [HASH_SLOTS];
	logic [EW-1:0]         rd_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic [AW-1:0]         addr_q;
	logic [CW-1:0]         count_q;
	logic [KW-1:0]         key_q;
	logic [CODE_BITS-1:0]  prefix_q;
	logic                  have_q;
	logic [NW-1:0]         next_q;
	logic [AW-1:0]         addr_inc;

	assign addr_inc = (addr_q == AW'(HASH_SLOTS - 1)) ? '0 : addr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.op == DP_READ) begin
			rd_q <= mem[addr_q];
		end else if (cmd.op == DP_INSERT) begin
			mem[addr_q] <= {epoch_q, key_q, next_q[CODE_BITS-1:0]};
		end else if (cmd.op == DP_CLEAR_STEP) begin
			mem[addr_q] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q    <= '0;
			addr_q     <= '0;
			count_q    <= '0;
			key_q      <= '0;
			prefix_q   <= '0;
			have_q     <= 1'b0;
			next_q     <= NW'(256);
		end else begin
			unique case (cmd.op)
				DP_LOAD: begin
					key_q   <= {prefix_q, in_byte};
					addr_q  <= AW'({prefix_q, in_byte} % HASH_SLOTS);
					count_q <= '0;
				end
				DP_READ: begin
				end
				DP_STEP: begin
					addr_q  <= addr_inc;
					count_q <= count_q + 1'b1;
				end
				DP_INSERT: begin
					next_q <= next_q + 1'b1;
				end
				DP_CLEAR_STEP: begin
					addr_q <= addr_inc;
					if (addr_q == AW'(HASH_SLOTS - 1)) begin
						epoch_q <= EPOCH_BITS'(1);
					end
				end
				DP_NOP: begin
				end
				default: begin
				end
			endcase
			if (cmd.take_hit) begin
				prefix_q <= rd_q[CODE_BITS-1:0];
			end
			if (cmd.set_byte) begin
				prefix_q <= have_q ? CODE_BITS'(key_q[BYTE_BITS-1:0]) : CODE_BITS'(in_byte);
				have_q   <= 1'b1;
			end
			if (cmd.clear_state) begin
				epoch_q  <= epoch_q + 1'b1;
				addr_q   <= '0;
				prefix_q <= '0;
				have_q   <= 1'b0;
				next_q   <= NW'(256);
			end
		end
	end

	assign prefix             = prefix_q;
	assign status.have_prefix = have_q;
	assign status.slot_valid  = (rd_q[EW-1:TW] == epoch_q);
	assign status.key_match   = (rd_q[TW-1:CODE_BITS] == key_q);
	assign status.probe_done  = (count_q == CW'(HASH_SLOTS - 1));
	assign status.can_insert  = (next_q < NW'(2**CODE_BITS));
	assign status.sweep_done  = (addr_q == AW'(HASH_SLOTS - 1));
	assign status.epoch_last  = &epoch_q;

endmodule
`default_nettype wire

[rtl/core/lzwe_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// LZW encoder controller
// Sequences requests through probe, emit, insert and flush, and runs the dictionary clearing sweep.
// ---------------------------------------------------------------------------
module lzwe_ctrl #(
	parameter int unsigned CODE_BITS = 12
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire                            end_of_data,
	input  wire                            out_ready,
	output logic                           out_valid,
	output logic [lzwe_pkg::OUT_BITS-1:0]  out_code,
	output logic                           last_code,
	input  lzwe_pkg::dp_status_t           status,
	input  wire [CODE_BITS-1:0]            prefix,
	output lzwe_pkg::dp_cmd_t              cmd
);
	import lzwe_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_CHECK, S_MISS, S_FLUSH, S_SWEEP
	} state_t;

	state_t state_q;
	logic   last_q;
	logic   out_free;
	logic   emit;

	assign out_free = !out_valid || out_ready;
	assign emit     = out_free && (state_q == S_MISS || state_q == S_FLUSH);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '{op: DP_NOP, take_hit: 1'b0, set_byte: 1'b0, clear_state: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (status.have_prefix) begin
						cmd.op = DP_LOAD;
					end else begin
						cmd.set_byte = 1'b1;
					end
				end
			end
			S_READ: cmd.op = DP_READ;
			S_CHECK: begin
				if (status.slot_valid && status.key_match) begin
					cmd.take_hit = 1'b1;
				end else if (status.slot_valid && !status.probe_done) begin
					cmd.op = DP_STEP;
				end
			end
			S_MISS: begin
				if (out_free) begin
					cmd.set_byte = 1'b1;
					if (status.can_insert && !status.slot_valid) begin
						cmd.op = DP_INSERT;
					end
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					cmd.clear_state = 1'b1;
				end
			end
			S_SWEEP: cmd.op = DP_CLEAR_STEP;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SWEEP;
			last_q    <= 1'b0;
			out_valid <= 1'b0;
			out_code  <= '0;
			last_code <= 1'b0;
		end else begin
			if (out_valid && out_ready && !emit) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q  <= end_of_data;
						if (status.have_prefix) begin
							state_q <= S_READ;
						end else if (end_of_data) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (status.slot_valid && status.key_match) begin
						state_q <= last_q ? S_FLUSH : S_IDLE;
					end else if (status.slot_valid && !status.probe_done) begin
						state_q <= S_READ;
					end else begin
						state_q <= S_MISS;
					end
				end
				S_MISS: begin
					if (out_free) begin
						out_valid <= 1'b1;
						out_code  <= OUT_BITS'(prefix);
						last_code <= 1'b0;
						state_q   <= last_q ? S_FLUSH : S_IDLE;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						out_valid <= 1'b1;
						out_code  <= OUT_BITS'(prefix);
						last_code <= 1'b1;
						state_q   <= status.epoch_last ? S_SWEEP : S_IDLE;
					end
				end
				S_SWEEP: begin
					if (status.sweep_done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/lzw_encoder_fixed_width.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// LZW encoder, fixed-width codes
// The first byte of a stream is loaded into the prefix directly; other
// bytes pass through a read and a check per hash probe, and a miss emits
// a code; an emit waits while the output register is still full. A new
// byte is taken only when idle, after the last request is done. Each
// probe reads the single-port dictionary memory once. Reset clears prefix
// and next free code, then a clearing pass over all HASH_SLOTS slots
// zeroes the dictionary; the pass repeats after every 255th stream flush.
// ---------------------------------------------------------------------------
module lzw_encoder_fixed_width #(
	parameter int unsigned CODE_BITS  = 12,
	parameter int unsigned HASH_SLOTS = 8192
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [lzwe_pkg::BYTE_BITS-1:0] in_byte,
	input  wire                            end_of_data,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [lzwe_pkg::OUT_BITS-1:0]  out_code,
	output logic                           last_code
);
	import lzwe_pkg::*;

	dp_cmd_t              cmd;
	dp_status_t           status;
	logic [CODE_BITS-1:0] prefix;

	lzwe_datapath #(.CODE_BITS(CODE_BITS), .HASH_SLOTS(HASH_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_byte(in_byte),
		.status(status), .prefix(prefix)
	);

	lzwe_ctrl #(.CODE_BITS(CODE_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.end_of_data(end_of_data), .out_ready(out_ready), .out_valid(out_valid),
		.out_code(out_code), .last_code(last_code), .status(status),
		.prefix(prefix), .cmd(cmd)
	);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_code))
		else $error("output dropped while stalled");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && status.have_prefix |=> !in_ready)
		else $error("request taken during probe");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_INSERT |-> status.can_insert && !status.slot_valid)
		else $error("insert into occupied slot or full dictionary");

endmodule
`default_nettype wire
